/* rtl/cbs_pkg.sv */
// Shared types and constants of the cubic Bezier sampler.
`timescale 1ns / 1ps

package cbs_pkg;

  // Coordinate format: signed Q2.14
  localparam int COORD_BITS = 16;

  // Default number of intervals per segment (STEPS+1 samples)
  localparam int STEPS_DEFAULT = 20;

  // Depth of the segment queue between front and back end
  localparam int SEG_Q_DEPTH = 2;

  // Depth of the result buffer on the output side
  localparam int OUT_Q_DEPTH = 2;

  // Pipeline stages of the constant divider
  localparam int DIV_LAT = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Four control points of one axis, index 0 is p0
  typedef coord_t [3:0] ctrl_axis_t;

  typedef struct packed {
    ctrl_axis_t x;
    ctrl_axis_t y;
  } segment_t;

  // One input item
  typedef struct packed {
    logic   new_curve;
    coord_t point_x;
    coord_t point_y;
  } point_t;

  // One result item
  typedef struct packed {
    coord_t curve_x;
    coord_t curve_y;
    logic   segment_end;
  } sample_t;

endpackage

/* rtl/cubic_bezier_sampler.sv */
// Top level of the piecewise cubic Bezier sampler.
`timescale 1ns / 1ps

// Control points (signed Q2.14) are pushed one per cycle while full is low; the
// fourth point of each segment (points 0-3, 3-6, ...) queues the segment and the
// back end then delivers STEPS+1 samples at t = k/STEPS, rounded to nearest with
// halves going up, the last one flagged by segment_end. The evaluator produces one
// sample per clock unless a finished sample finds the result buffer full, and it
// fetches the next segment once the last step of the current one is issued. With
// the back end idle, a closing point's segment passes the segment queue and the
// fetch, then its first sample is issued into the four weighting stages and the
// three-stage constant divider and is written to the result buffer. Points are
// taken every cycle while the two-entry segment queue has room; full rises when it
// has none. new_curve drops any incomplete segment without output.
module cubic_bezier_sampler #(
  parameter int STEPS = cbs_pkg::STEPS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  cbs_pkg::point_t  point,
  output logic             empty,
  input  logic             pop,
  output cbs_pkg::sample_t sample
);
  import cbs_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  segment_t q_wdata;
  segment_t q_rdata;

  cbs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .point    (point),
    .seg_push (q_push),
    .seg_full (q_full),
    .seg      (q_wdata)
  );

  cbs_seg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  cbs_eval #(
    .STEPS (STEPS)
  ) u_eval (
    .clk       (clk),
    .rst       (rst),
    .seg_pop   (q_pop),
    .seg_empty (q_empty),
    .seg       (q_rdata),
    .empty     (empty),
    .pop       (pop),
    .sample    (sample)
  );

endmodule

/* rtl/cbs_front.sv */
// Front end: collects control points and hands complete segments to the queue.
`timescale 1ns / 1ps

module cbs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  cbs_pkg::point_t   point,
  output logic              seg_push,
  input  logic              seg_full,
  output cbs_pkg::segment_t seg
);
  import cbs_pkg::*;

  logic       anchor_valid;
  logic [1:0] held;
  coord_t     px [3];
  coord_t     py [3];
  logic       accept;
  logic       restart;

  // A point may complete a segment, so only take it with queue room
  assign full    = seg_full;
  assign accept  = push && !full;
  assign restart = point.new_curve || !anchor_valid || (held == 2'd0);

  assign seg_push = accept && !restart && (held == 2'd3);
  assign seg.x    = {point.point_x, px[2], px[1], px[0]};
  assign seg.y    = {point.point_y, py[2], py[1], py[0]};

  // Point count and anchor flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= 2'd0;
      anchor_valid <= 1'b0;
    end else if (accept) begin
      anchor_valid <= 1'b1;
      if (restart || held == 2'd3) begin
        held <= 2'd1;
      end else begin
        held <= held + 2'd1;
      end
    end
  end

  // Stored points; the closing point of a segment becomes the next anchor
  always_ff @(posedge clk) begin
    if (accept) begin
      if (restart || held == 2'd3) begin
        px[0] <= point.point_x;
        py[0] <= point.point_y;
      end else begin
        px[held] <= point.point_x;
        py[held] <= point.point_y;
      end
    end
  end

endmodule

/* rtl/cbs_seg_queue.sv */
// Short queue of complete segments between front and back end.
`timescale 1ns / 1ps

module cbs_seg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  cbs_pkg::segment_t wdata,
  input  logic              pop,
  output logic              empty,
  output cbs_pkg::segment_t rdata
);
  import cbs_pkg::*;

  localparam int PTR_W = (SEG_Q_DEPTH > 1) ? $clog2(SEG_Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(SEG_Q_DEPTH + 1);

  segment_t         mem [SEG_Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(SEG_Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(SEG_Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(SEG_Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

/* rtl/cbs_div.sv */
// Three-stage division by a constant: reciprocal estimate, then remainder fix-up.
`timescale 1ns / 1ps

module cbs_div #(
  parameter int M_W     = 35,
  parameter int DIVISOR = 16000,
  parameter int Q_W     = 16
) (
  input  logic           clk,
  input  logic           en,
  input  logic [M_W-1:0] num,
  output logic [Q_W-1:0] quo
);

  // num stays below DIVISOR * 2^Q_W, so num >> T fits in Q_W+1 bits; the
  // truncated reciprocal then falls short of the quotient by at most two
  localparam int L   = $clog2(DIVISOR);
  localparam int T   = L - 1;
  localparam int H_W = Q_W + 1;
  localparam int P_W = 2 * H_W;
  localparam longint RECIP = (longint'(1) << (L + Q_W)) / longint'(DIVISOR);
  localparam logic [H_W-1:0] RECIP_C = H_W'(RECIP);
  localparam logic [M_W-1:0] DIV_C   = M_W'(DIVISOR);
  localparam logic [M_W-1:0] DIV2_C  = M_W'(2 * DIVISOR);

  logic [H_W-1:0] num_hi;
  logic [P_W-1:0] prod1;
  logic [M_W-1:0] num1;
  logic [Q_W-1:0] est;
  logic [Q_W-1:0] est2;
  logic [M_W-1:0] rem2;

  assign num_hi = H_W'(num >> T);
  assign est    = prod1[Q_W+1 +: Q_W];

  // Estimate, remainder, then add back the one or two missing units
  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= P_W'(num_hi) * P_W'(RECIP_C);
      num1  <= num;
      est2  <= est;
      rem2  <= num1 - M_W'(est) * DIV_C;
      quo   <= est2 + Q_W'(rem2 >= DIV_C) + Q_W'(rem2 >= DIV2_C);
    end
  end

endmodule

/* rtl/cbs_eval.sv */
// Back end: steps t over a segment, weights the points, divides and buffers samples.
`timescale 1ns / 1ps

module cbs_eval #(
  parameter int STEPS = cbs_pkg::STEPS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  output logic              seg_pop,
  input  logic              seg_empty,
  input  cbs_pkg::segment_t seg,
  output logic              empty,
  input  logic              pop,
  output cbs_pkg::sample_t  sample
);
  import cbs_pkg::*;

  localparam int K_W    = $clog2(STEPS + 1);
  localparam int TAB_N  = 2 ** K_W;
  localparam int DEN    = STEPS * STEPS * STEPS;
  localparam int WGT_W  = $clog2(DEN + 1);
  localparam int PROD_W = WGT_W + COORD_BITS + 1;
  localparam int M_W    = WGT_W + COORD_BITS + 1;
  localparam int LAT    = 4 + DIV_LAT;
  localparam longint MOFF = longint'(DEN) * ((longint'(1) << COORD_BITS) + 1);
  localparam logic signed [M_W:0] MOFF_S = (M_W + 1)'(MOFF);
  localparam int OPTR_W = (OUT_Q_DEPTH > 1) ? $clog2(OUT_Q_DEPTH) : 1;
  localparam int OCNT_W = $clog2(OUT_Q_DEPTH + 1);

  typedef logic [WGT_W-1:0] wgt_t;

  // Sequencer
  segment_t       seg_cur;
  logic           busy;
  logic [K_W-1:0] k;
  logic           issue;
  logic           adv;

  // Pipeline
  wgt_t                    wtab [TAB_N][4];
  wgt_t                    w1 [4];
  coord_t                  pt1 [2][4];
  logic signed [PROD_W-1:0] prod2 [2][4];
  logic signed [M_W:0]     sa3 [2];
  logic signed [M_W:0]     sb3 [2];
  logic [M_W-1:0]          m4 [2];
  logic [COORD_BITS-1:0]   quo [2];
  logic [LAT-1:0]          vpipe;
  logic [LAT-1:0]          epipe;
  logic                    end1;

  // Result buffer
  sample_t           o_mem [OUT_Q_DEPTH];
  logic [OPTR_W-1:0] o_wr;
  logic [OPTR_W-1:0] o_rd;
  logic [OCNT_W-1:0] o_count;
  logic              o_full;
  logic              o_push;
  logic              o_pop;
  sample_t           o_data;

  // Bernstein weights per step, constant per entry
  always_comb begin
    int u;
    for (int g = 0; g < TAB_N; g++) begin
      u = STEPS - g;
      if (g <= STEPS) begin
        wtab[g][0] = WGT_W'(u * u * u);
        wtab[g][1] = WGT_W'(3 * g * u * u);
        wtab[g][2] = WGT_W'(3 * g * g * u);
        wtab[g][3] = WGT_W'(g * g * g);
      end else begin
        for (int i = 0; i < 4; i++) begin
          wtab[g][i] = '0;
        end
      end
    end
  end

  // Whole pipeline halts while a finished sample has nowhere to go
  assign o_full  = (o_count == OCNT_W'(OUT_Q_DEPTH));
  assign adv     = !(vpipe[LAT-1] && o_full);
  assign issue   = busy && adv;
  assign seg_pop = !busy && !seg_empty;
  assign o_push  = vpipe[LAT-1] && adv;
  assign empty   = (o_count == '0);
  assign o_pop   = pop && !empty;

  // Sequencer and valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      k     <= '0;
      vpipe <= '0;
    end else begin
      if (seg_pop) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (issue) begin
        if (k == K_W'(STEPS)) begin
          busy <= 1'b0;
        end else begin
          k <= k + 1'b1;
        end
      end
      if (adv) begin
        vpipe <= {vpipe[LAT-2:0], issue};
      end
    end
  end

  assign end1 = (k == K_W'(STEPS));

  // Current segment
  always_ff @(posedge clk) begin
    if (seg_pop) begin
      seg_cur <= seg;
    end
  end

  // Datapath: weights, products, pair sums, offset numerator
  always_ff @(posedge clk) begin
    if (adv) begin
      epipe <= {epipe[LAT-2:0], end1};
      for (int i = 0; i < 4; i++) begin
        w1[i]     <= wtab[k][i];
        pt1[0][i] <= seg_cur.x[i];
        pt1[1][i] <= seg_cur.y[i];
      end
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 4; i++) begin
          prod2[a][i] <= $signed({1'b0, w1[i]}) * pt1[a][i];
        end
        sa3[a] <= (M_W + 1)'(prod2[a][0]) + (M_W + 1)'(prod2[a][1]);
        sb3[a] <= (M_W + 1)'(prod2[a][2]) + (M_W + 1)'(prod2[a][3]);
        // 2*num + den, shifted up by half the quotient range to stay positive
        m4[a]  <= M_W'(((sa3[a] + sb3[a]) <<< 1) + MOFF_S);
      end
    end
  end

  // Rounding division by 2*S^3, one divider per axis
  for (genvar a = 0; a < 2; a++) begin : g_axis
    cbs_div #(
      .M_W     (M_W),
      .DIVISOR (2 * DEN),
      .Q_W     (COORD_BITS)
    ) u_div (
      .clk (clk),
      .en  (adv),
      .num (m4[a]),
      .quo (quo[a])
    );
  end

  // Undo the offset by flipping the sign bit
  assign o_data.curve_x     = coord_t'({~quo[0][COORD_BITS-1], quo[0][COORD_BITS-2:0]});
  assign o_data.curve_y     = coord_t'({~quo[1][COORD_BITS-1], quo[1][COORD_BITS-2:0]});
  assign o_data.segment_end = epipe[LAT-1];

  // Result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr    <= '0;
      o_rd    <= '0;
      o_count <= '0;
    end else begin
      if (o_push) begin
        o_wr <= (o_wr == OPTR_W'(OUT_Q_DEPTH - 1)) ? '0 : o_wr + 1'b1;
      end
      if (o_pop) begin
        o_rd <= (o_rd == OPTR_W'(OUT_Q_DEPTH - 1)) ? '0 : o_rd + 1'b1;
      end
      if (o_push && !o_pop) begin
        o_count <= o_count + 1'b1;
      end else if (o_pop && !o_push) begin
        o_count <= o_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      o_mem[o_wr] <= o_data;
    end
  end

  assign sample = o_mem[o_rd];

  // Checks
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (k <= K_W'(STEPS)))
    else $error("step counter beyond last step");

  a_load: assert property (@(posedge clk) disable iff (rst)
    seg_pop |=> (busy && k == '0))
    else $error("segment fetch did not start at step zero");

  a_buf_cnt: assert property (@(posedge clk) disable iff (rst)
    o_count <= OCNT_W'(OUT_Q_DEPTH))
    else $error("result buffer overflow");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vpipe))
    else $error("pipeline moved during stall");

endmodule
